@@ rtl/balist_pkg.sv @@
// Shared types and codes for the bounded array list engine.
// No dependencies; used by balist_seq, the top level and the testbench.
package balist_pkg;

  typedef enum logic [2:0] {
    ACT_GET    = 3'd0,
    ACT_SET    = 3'd1,
    ACT_APPEND = 3'd2,
    ACT_SEARCH = 3'd3,
    ACT_REMOVE = 3'd4,
    ACT_INSERT = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } seq_state_e;

  localparam logic [6:0] CAP_RESET = 7'd64;

  typedef struct packed {
    logic        [2:0]  action;
    logic        [6:0]  position;
    logic signed [31:0] operand_value;
  } req_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] read_value;
    logic        [5:0]  found_index;
    logic        [6:0]  list_size;
  } rsp_t;

  // ring control from the sequencer to the cell chain
  typedef struct packed {
    logic        shift;
    logic [31:0] tail;
  } ring_ctl_t;

endpackage

@@ rtl/bounded_array_list_engine.sv @@
// Channel  | Signals                               | Direction
// ---------+---------------------------------------+----------
// request  | in_valid_i, in_ready_o, in_req_i      | in
// result   | out_valid_o, out_ready_i, out_rsp_o   | out
// config   | cfg_we_i, cfg_wdata_i                 | in
//
// Entries live in a ring of DEPTH cells that rotates one place per cycle while a request runs.
// Get, set, append, search, remove and insert take one full rotation;
// the result register is loaded from S_DONE and the next request is taken
// once the sequencer is back in S_IDLE. Refused or unused requests skip the rotation.
// Reset empties the list and sets the capacity to 64; the cells keep no reset.
// A stalled result holds the sequencer in its final step; nothing rotates.
// Depends on balist_pkg, balist_cell and balist_seq.
module bounded_array_list_engine import balist_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  req_t       in_req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output rsp_t       out_rsp_o
);

  logic [31:0] cell_data [DEPTH];
  ring_ctl_t   ctl;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [31:0] next_w;
    if (i == DEPTH - 1) begin : g_tail
      assign next_w = ctl.tail;
    end else begin : g_body
      assign next_w = cell_data[i+1];
    end
    balist_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (ctl.shift),
      .next_i  (next_w),
      .data_o  (cell_data[i])
    );
  end

  balist_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .head_i      (cell_data[0]),
    .next_i      (cell_data[1]),
    .ctl_o       (ctl)
  );

  // the ring never rotates while a request can be taken
  a_shift_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.shift |-> !in_ready_o)
    else $error("ring rotates while idle");

  // a taken request leaves the engine not ready in the following cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while busy");

  // failed requests never carry a read value or an index
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.status != ST_OK) |->
      (out_rsp_o.read_value == 32'sd0 && out_rsp_o.found_index == 6'd0))
    else $error("failed request returns data");

endmodule

@@ rtl/balist_cell.sv @@
// One storage cell of the list ring: holds one entry, takes its neighbor's
// entry on every shift. Depends on nothing.
module balist_cell (
  input  logic        clk_i,
  input  logic        shift_i,
  input  logic [31:0] next_i,
  output logic [31:0] data_o
);

  logic [31:0] data_q;
  logic [31:0] data_d;

  assign data_d = shift_i ? next_i : data_q;

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

@@ rtl/balist_seq.sv @@
// Sequencer for the list ring: request decode, step counter, stream rewrite
// at the ring tail, search/get capture, entry count and result register.
// Depends on balist_pkg.
module balist_seq import balist_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  req_t        in_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rsp_t        out_rsp_o,
  input  logic [31:0] head_i,
  input  logic [31:0] next_i,
  output ring_ctl_t   ctl_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = CW + IW + 7;
  localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);
  localparam logic [IW-1:0] LAST_STEP = IW'(DEPTH - 1);

  seq_state_e  state_q, state_d;
  logic [IW-1:0] step_q;
  logic [2:0]  act_q;
  logic [6:0]  pos_q;
  logic [31:0] word_q;
  logic [1:0]  status_q;
  logic        found_q;
  logic [IW-1:0] fidx_q;
  logic [31:0] read_q;
  logic [31:0] hold_q;
  logic [CW-1:0] count_q, count_d;
  logic [6:0]  cap_q;
  logic        out_valid_q;
  rsp_t        rsp_q;

  logic [XW-1:0] cnt_x, pos_in_x, pos_x, step_x, cap_x, eff_cap;
  logic          in_range, ins_ok, full, run;
  logic [1:0]    st_in;
  logic          accept, emit;
  logic [1:0]    st_out;
  logic [IW+5:0] fidx_ext;
  logic [CW+6:0] size_ext;
  logic [31:0]   tail;

  assign cnt_x    = XW'(count_q);
  assign pos_in_x = XW'(in_req_i.position);
  assign pos_x    = XW'(pos_q);
  assign step_x   = XW'(step_q);
  assign cap_x    = XW'(cap_q);
  assign eff_cap  = (cap_x < DEPTH_X) ? cap_x : DEPTH_X;

  assign in_range = pos_in_x < cnt_x;
  assign ins_ok   = pos_in_x <= cnt_x;
  assign full     = cnt_x >= eff_cap;

  always_comb begin
    st_in = ST_OK;
    run   = 1'b0;
    unique case (in_req_i.action) inside
      ACT_GET, ACT_SET, ACT_REMOVE: begin
        st_in = in_range ? ST_OK : ST_RANGE;
        run   = in_range;
      end
      ACT_APPEND: begin
        st_in = full ? ST_FULL : ST_OK;
        run   = !full;
      end
      ACT_SEARCH: begin
        run = 1'b1;
      end
      ACT_INSERT: begin
        if (!ins_ok) begin
          st_in = ST_RANGE;
        end else if (full) begin
          st_in = ST_FULL;
        end else begin
          run = 1'b1;
        end
      end
      default: begin
        st_in = ST_OK;
        run   = 1'b0;
      end
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign emit       = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // rewrite of the entry stream entering the ring tail
  always_comb begin
    tail = head_i;
    case (act_q)
      ACT_SET:    tail = (step_x == pos_x) ? word_q : head_i;
      ACT_APPEND: tail = (step_x == cnt_x) ? word_q : head_i;
      ACT_INSERT: begin
        if (step_x < pos_x) begin
          tail = head_i;
        end else if (step_x == pos_x) begin
          tail = word_q;
        end else begin
          tail = hold_q;
        end
      end
      ACT_REMOVE: tail = (step_x >= pos_x) ? next_i : head_i;
      default:    tail = head_i;
    endcase
  end

  assign ctl_o.shift = (state_q == S_RUN);
  assign ctl_o.tail  = tail;

  always_comb begin
    count_d = count_q;
    if (status_q == ST_OK) begin
      case (act_q) inside
        ACT_APPEND, ACT_INSERT: count_d = count_q + CW'(1);
        ACT_REMOVE:             count_d = count_q - CW'(1);
        default:                count_d = count_q;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = run ? S_RUN : S_DONE;
      S_RUN:  if (step_q == LAST_STEP) state_d = S_DONE;
      S_DONE: if (emit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign st_out   = (act_q == ACT_SEARCH) ? (found_q ? ST_OK : ST_MISSING) : status_q;
  assign fidx_ext = {6'b0, fidx_q};
  assign size_ext = {7'b0, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      count_q     <= '0;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        step_q  <= '0;
        found_q <= 1'b0;
      end
      if (state_q == S_RUN) begin
        step_q <= step_q + IW'(1);
        if (act_q == ACT_SEARCH && !found_q && step_x < cnt_x && head_i == word_q) begin
          found_q <= 1'b1;
        end
      end
      if (emit) begin
        count_q <= count_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q    <= in_req_i.action;
      pos_q    <= in_req_i.position;
      word_q   <= in_req_i.operand_value;
      status_q <= st_in;
      fidx_q   <= '0;
      read_q   <= '0;
    end
    if (state_q == S_RUN) begin
      hold_q <= head_i;
      if (act_q == ACT_SEARCH && !found_q && step_x < cnt_x && head_i == word_q) begin
        fidx_q <= step_q;
      end
      if (act_q == ACT_GET && step_x == pos_x) begin
        read_q <= head_i;
      end
    end
    if (emit) begin
      rsp_q.status      <= st_out;
      rsp_q.read_value  <= read_q;
      rsp_q.found_index <= fidx_ext[5:0];
      rsp_q.list_size   <= size_ext[6:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for bounded_array_list_engine: list requests are driven with
// random gaps and result back-pressure, and each result is checked against a list model.
// Depends on balist_pkg and the engine RTL.
module testbench;
  import balist_pkg::*;

  localparam int DEPTH = 64;
  localparam int CYCLE_LIMIT = 800000;
  localparam int MAX_REPORTS = 10;
  // action codes the engine leaves unused
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;

  class list_scoreboard;
    logic [31:0] entries [DEPTH];
    int unsigned entry_count;
    int unsigned capacity_limit;
    int unsigned mismatch_count;
    rsp_t expected_rsps [$];

    function new();
      entry_count = 0;
      capacity_limit = CAP_RESET;
      mismatch_count = 0;
    endfunction

    function int unsigned effective_capacity();
      return (capacity_limit < DEPTH) ? capacity_limit : DEPTH;
    endfunction

    function int unsigned pending();
      return expected_rsps.size();
    endfunction

    // applies one request to the model list and returns the result it should give
    function rsp_t apply_list_op(req_t r);
      rsp_t want;
      int unsigned pos;
      want = '0;
      pos = r.position;
      case (action_e'(r.action))
        ACT_GET: begin
          if (pos < entry_count) want.read_value = entries[pos];
          else want.status = ST_RANGE;
        end
        ACT_SET: begin
          if (pos < entry_count) entries[pos] = r.operand_value;
          else want.status = ST_RANGE;
        end
        ACT_APPEND: begin
          if (entry_count >= effective_capacity()) begin
            want.status = ST_FULL;
          end else begin
            entries[entry_count] = r.operand_value;
            entry_count++;
          end
        end
        ACT_SEARCH: begin
          want.status = ST_MISSING;
          for (int i = 0; i < entry_count; i++) begin
            if (entries[i] == r.operand_value) begin
              want.status = ST_OK;
              want.found_index = 6'(i);
              break;
            end
          end
        end
        ACT_REMOVE: begin
          if (pos < entry_count) begin
            for (int i = pos; i + 1 < entry_count; i++) entries[i] = entries[i + 1];
            entry_count--;
          end else begin
            want.status = ST_RANGE;
          end
        end
        ACT_INSERT: begin
          // index test comes before the full test
          if (pos > entry_count) begin
            want.status = ST_RANGE;
          end else if (entry_count >= effective_capacity()) begin
            want.status = ST_FULL;
          end else begin
            for (int i = entry_count; i > pos; i--) entries[i] = entries[i - 1];
            entries[pos] = r.operand_value;
            entry_count++;
          end
        end
        default: ;
      endcase
      want.list_size = 7'(entry_count);
      return want;
    endfunction

    function void record_request(req_t r);
      expected_rsps.push_back(apply_list_op(r));
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (expected_rsps.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("ERROR: unexpected result: status %0d read %0d index %0d size %0d",
                   got.status, got.read_value, got.found_index, got.list_size);
        return;
      end
      want = expected_rsps.pop_front();
      if (got.status !== want.status || got.read_value !== want.read_value ||
          got.found_index !== want.found_index || got.list_size !== want.list_size) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("ERROR: exp st %0d rd %0d idx %0d sz %0d, got st %0d rd %0d idx %0d sz %0d",
                   want.status, want.read_value, want.found_index, want.list_size,
                   got.status, got.read_value, got.found_index, got.list_size);
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [6:0] cfg_wdata_i = CAP_RESET;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  req_t       in_req_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  rsp_t       out_rsp_o;

  list_scoreboard sb;
  bit idling_on = 1'b1;
  int cycle_count = 0;

  bounded_array_list_engine #(.DEPTH(DEPTH)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) sb.check_result(out_rsp_o);
  end

  always begin : result_backpressure
    @(posedge clk_i);
    if (idling_on && $urandom_range(0, 7) == 0) begin
      out_ready_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    out_ready_i <= 1'b1;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  function automatic req_t make_request(logic [2:0] act, int unsigned pos, logic [31:0] word);
    req_t r;
    r.action = act;
    r.position = 7'(pos);
    r.operand_value = word;
    return r;
  endfunction

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 5))
      0, 1: return $urandom();
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return '0;
          default: return '1;
        endcase
      end
      // small pool so duplicates and search hits are common
      default: return 32'($urandom_range(0, 15)) - 32'd8;
    endcase
  endfunction

  // grow biases toward append/insert, otherwise toward remove
  function automatic req_t random_list_request(bit grow);
    int unsigned roll;
    int unsigned count;
    int unsigned pos;
    logic [2:0] act;
    logic [31:0] word;
    count = sb.entry_count;
    roll = $urandom_range(0, 99);
    if (roll < 12) act = ACT_GET;
    else if (roll < 22) act = ACT_SET;
    else if (roll < (grow ? 47 : 30)) act = ACT_APPEND;
    else if (roll < (grow ? 72 : 38)) act = ACT_INSERT;
    else if (roll < 82) act = ACT_REMOVE;
    else if (roll < 97) act = ACT_SEARCH;
    else act = roll[0] ? ACT_SPARE_7 : ACT_SPARE_6;
    case ($urandom_range(0, 9))
      0: pos = $urandom_range(0, 127);
      1: pos = count;
      default: pos = (count == 0) ? 0 : $urandom_range(0, count - 1);
    endcase
    if (act == ACT_SEARCH && count != 0 && $urandom_range(0, 9) < 6)
      word = sb.entries[$urandom_range(0, count - 1)];
    else
      word = random_word();
    return make_request(act, pos, word);
  endfunction

  task automatic send_request(input req_t r);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    sb.record_request(r);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_capacity(input int unsigned cap);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= 7'(cap);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.capacity_limit = cap;
  endtask

  task automatic run_random_phase(input int unsigned n_items);
    bit grow;
    grow = 1'b1;
    repeat (n_items) begin
      if (sb.entry_count >= sb.effective_capacity()) grow = 1'b0;
      else if (sb.entry_count == 0) grow = 1'b1;
      else if ($urandom_range(0, 39) == 0) grow = !grow;
      send_request(random_list_request(grow));
    end
  endtask

  initial begin : stimulus
    int unsigned phase_cap [6];
    int unsigned phase_len [6];
    phase_cap = '{64, 9, 2, 33, 64, 48};
    phase_len = '{250, 150, 150, 200, 250, 250};
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list
    send_request(make_request(ACT_GET, 0, 0));
    send_request(make_request(ACT_REMOVE, 0, 0));
    send_request(make_request(ACT_SEARCH, 0, 0));
    send_request(make_request(ACT_INSERT, 1, 32'h1));
    // fill with extreme words, insert at front, end and middle
    send_request(make_request(ACT_INSERT, 0, 32'h8000_0000));
    send_request(make_request(ACT_APPEND, 0, 32'h7fff_ffff));
    send_request(make_request(ACT_APPEND, 0, '1));
    send_request(make_request(ACT_APPEND, 0, '0));
    send_request(make_request(ACT_INSERT, sb.entry_count, 32'd5));
    send_request(make_request(ACT_INSERT, 1, 32'h1234_5678));
    send_request(make_request(ACT_GET, 0, 0));
    send_request(make_request(ACT_GET, sb.entry_count - 1, 0));
    send_request(make_request(ACT_GET, sb.entry_count, 0));
    send_request(make_request(ACT_GET, 127, 0));
    send_request(make_request(ACT_SET, 2, 32'ha5a5_a5a5));
    send_request(make_request(ACT_SET, sb.entry_count, 32'h5a5a_5a5a));
    send_request(make_request(ACT_SEARCH, 0, '1));
    send_request(make_request(ACT_SEARCH, 0, 32'h7fff_ffff));
    send_request(make_request(ACT_SEARCH, 0, 32'h0bad_f00d));
    // duplicate value: search must report the first one
    send_request(make_request(ACT_APPEND, 0, '0));
    send_request(make_request(ACT_SEARCH, 0, '0));
    send_request(make_request(ACT_REMOVE, 0, 0));
    send_request(make_request(ACT_REMOVE, sb.entry_count - 1, 0));
    send_request(make_request(ACT_REMOVE, sb.entry_count, 0));
    send_request(make_request(ACT_SPARE_6, 3, 32'h1));
    send_request(make_request(ACT_SPARE_7, 127, '1));

    // capacity dropped below the current size: entries stay, growth is refused
    write_capacity(1);
    send_request(make_request(ACT_APPEND, 0, 32'h77));
    send_request(make_request(ACT_INSERT, 0, 32'h77));
    send_request(make_request(ACT_INSERT, 100, 32'h77));
    run_random_phase(150);

    for (int p = 0; p < 6; p++) begin
      write_capacity(phase_cap[p]);
      if (p == 5) idling_on = 1'b0;
      run_random_phase(phase_len[p]);
    end

    wait_idle();
    repeat (DEPTH + 8) @(posedge clk_i);
    if (sb.mismatch_count == 0 && sb.pending() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/balist_pkg.sv
rtl/balist_cell.sv
rtl/balist_seq.sv
rtl/bounded_array_list_engine.sv
test/testbench.sv
